>>> rtl/pea_pkg.sv
// Shared types, constants and helper functions of the polyline end-angle block.
package pea_pkg;

    localparam int MAX_POINTS_DEF   = 1024;
    localparam int CORDIC_STEPS_DEF = 16;

    // Width of the scan start index carried in a job, enough for stores of up to 65536 points
    localparam int IDX_FIELD_W = 16;

    // CORDIC datapath widths: vectors grow by about 1.65 over 33-bit differences
    localparam int CRD_XW = 36;
    localparam int CRD_ZW = 35;

    localparam logic signed [CRD_ZW-1:0] PI_Q30 = 35'sd3373259426;
    localparam logic [15:0]              PI_Q13 = 16'd25736;

    localparam logic [1:0] ST_NORMAL   = 2'd0;
    localparam logic [1:0] ST_SINGLE   = 2'd1;
    localparam logic [1:0] ST_IDENT    = 2'd2;
    localparam logic [1:0] ST_OVERFLOW = 2'd3;

    // atan(2^-i) in Q0.30 radians
    localparam logic [29:0] ATAN_TAB [32] = '{
        30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158, 30'd67021686,
        30'd33543515,  30'd16775850,  30'd8388437,   30'd4194282,   30'd2097149,
        30'd1048575,   30'd524287,    30'd262143,    30'd131071,    30'd65535,
        30'd32767,     30'd16383,     30'd8191,      30'd4095,      30'd2047,
        30'd1023,      30'd511,       30'd255,       30'd127,       30'd63,
        30'd31,        30'd15,        30'd8,         30'd4,         30'd2,
        30'd1,         30'd0
    };

    typedef struct packed {
        logic signed [31:0] x_coord;
        logic signed [31:0] y_coord;
        logic               last_point;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] begin_angle;
        logic signed [15:0] end_angle;
        logic [1:0]         line_status;
        logic               within_threshold;
    } out_item_t;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
    } point_t;

    // One closed line handed from the loader to the angle engine
    typedef struct packed {
        logic [1:0]             status;
        logic                   near_all;
        logic                   bank;
        logic                   do_scan;
        logic [IDX_FIELD_W-1:0] scan_start;
        point_t                 p_first;
        point_t                 p_begin;
        point_t                 p_last;
        point_t                 p_before_last;
    } job_t;

    typedef struct packed {
        logic en;
        logic bank;
    } bank_release_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_BEG_GO,
        BK_BEG_WAIT,
        BK_SCAN,
        BK_END_GO,
        BK_END_WAIT,
        BK_OUT
    } back_state_t;

    typedef enum logic [1:0] {
        CR_IDLE,
        CR_ROT,
        CR_FIN
    } cordic_state_t;

    function automatic logic signed [CRD_ZW-1:0] atan_entry(input logic [4:0] i);
        return $signed({5'b0, ATAN_TAB[i]});
    endfunction

    // True when a and b are more than thr apart on either axis
    function automatic logic differs(input point_t a, input point_t b, input logic [30:0] thr);
        logic signed [32:0] dx;
        logic signed [32:0] dy;
        logic [32:0]        mx;
        logic [32:0]        my;
        dx = 33'(a.x) - 33'(b.x);
        dy = 33'(a.y) - 33'(b.y);
        mx = dx[32] ? 33'(-dx) : 33'(dx);
        my = dy[32] ? 33'(-dy) : 33'(dy);
        return ({2'b0, thr} < mx) || ({2'b0, thr} < my);
    endfunction

endpackage

>>> rtl/pea_ram.sv
// Generic simple dual-port RAM with registered read.
module pea_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 2048,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/pea_fifo.sv
// Two-entry job queue between the point loader and the angle engine.
module pea_fifo import pea_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    input  logic pop,
    output job_t head_job,
    output logic empty
);

    job_t       mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    assign head_job = mem_reg[rd_ptr_reg];
    assign empty    = (cnt_reg == 2'd0);

endmodule

>>> rtl/pea_front.sv
// Point loader: stores points, tracks first/previous points and closes lines into jobs.
module pea_front import pea_pkg::*; #(
    parameter int MAX_POINTS = MAX_POINTS_DEF,
    localparam int IDX_W = $clog2(MAX_POINTS),
    localparam int CNT_W = $clog2(MAX_POINTS + 1)
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  in_item_t      in_data,
    input  logic [30:0]   threshold,
    output logic          wr_en,
    output logic [IDX_W:0] wr_addr,
    output point_t        wr_data,
    output logic          push,
    output job_t          push_job,
    input  bank_release_t bank_rel
);

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             ovf_reg, ovf_next;
    logic             bank_reg, bank_next;
    logic [1:0]       busy_reg, busy_next;
    point_t           p0_reg, p0_next;
    point_t           p1_reg, p1_next;
    point_t           prev_reg, prev_next;
    point_t           fd_reg, fd_next;
    logic             fd_found_reg, fd_found_next;
    logic             within_reg, within_next;
    logic             ident_reg, ident_next;

    point_t pt;
    logic   accept;
    logic   store;
    logic   dif;
    logic   same_prev;
    logic   within_fin;
    logic   ident_fin;

    assign pt        = point_t'{x: in_data.x_coord, y: in_data.y_coord};
    assign in_ready  = !busy_reg[bank_reg];
    assign accept    = in_valid && in_ready;
    assign store     = accept && (cnt_reg < CNT_W'(MAX_POINTS));
    assign dif       = differs(pt, p0_reg, threshold);
    assign same_prev = (pt == prev_reg);
    assign within_fin = (cnt_reg == '0) ? 1'b1 : (within_reg && !dif);
    assign ident_fin  = ident_reg && same_prev;

    assign wr_en   = store;
    assign wr_addr = {bank_reg, cnt_reg[IDX_W-1:0]};
    assign wr_data = pt;
    assign push    = accept && in_data.last_point;

    always_comb
    begin
        push_job.bank          = bank_reg;
        push_job.p_first       = p0_reg;
        push_job.p_last        = pt;
        push_job.p_before_last = prev_reg;
        push_job.do_scan       = (cnt_reg >= CNT_W'(2));
        push_job.scan_start    = IDX_FIELD_W'(cnt_reg - CNT_W'(1));
        if (fd_found_reg)
        begin
            push_job.p_begin = fd_reg;
        end
        else if (cnt_reg == CNT_W'(1))
        begin
            push_job.p_begin = pt;
        end
        else
        begin
            push_job.p_begin = p1_reg;
        end
        priority if (ovf_reg || !store)
        begin
            push_job.status = ST_OVERFLOW;
        end
        else if (cnt_reg == '0)
        begin
            push_job.status = ST_SINGLE;
        end
        else if (ident_fin)
        begin
            push_job.status = ST_IDENT;
        end
        else
        begin
            push_job.status = ST_NORMAL;
        end
        push_job.near_all = within_fin && !ovf_reg && store;
    end

    always_comb
    begin
        cnt_next      = cnt_reg;
        ovf_next      = ovf_reg;
        bank_next     = bank_reg;
        busy_next     = busy_reg;
        p0_next       = p0_reg;
        p1_next       = p1_reg;
        prev_next     = prev_reg;
        fd_next       = fd_reg;
        fd_found_next = fd_found_reg;
        within_next   = within_reg;
        ident_next    = ident_reg;

        if (bank_rel.en)
        begin
            busy_next[bank_rel.bank] = 1'b0;
        end

        if (store)
        begin
            if (cnt_reg == '0)
            begin
                p0_next       = pt;
                within_next   = 1'b1;
                ident_next    = 1'b1;
                fd_found_next = 1'b0;
            end
            else
            begin
                within_next = within_reg && !dif;
                ident_next  = ident_fin;
                if (!fd_found_reg && dif)
                begin
                    fd_found_next = 1'b1;
                    fd_next       = pt;
                end
            end
            if (cnt_reg == CNT_W'(1))
            begin
                p1_next = pt;
            end
            prev_next = pt;
            cnt_next  = cnt_reg + CNT_W'(1);
        end
        else if (accept)
        begin
            ovf_next = 1'b1;
        end

        // close the line and hand its bank to the engine
        if (push)
        begin
            cnt_next            = '0;
            ovf_next            = 1'b0;
            bank_next           = !bank_reg;
            busy_next[bank_reg] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            ovf_reg  <= 1'b0;
            bank_reg <= 1'b0;
            busy_reg <= 2'b00;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            ovf_reg  <= ovf_next;
            bank_reg <= bank_next;
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p0_reg       <= p0_next;
        p1_reg       <= p1_next;
        prev_reg     <= prev_next;
        fd_reg       <= fd_next;
        fd_found_reg <= fd_found_next;
        within_reg   <= within_next;
        ident_reg    <= ident_next;
    end

    a_push_free_bank: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !busy_reg[bank_reg])
        else $error("line closed into a bank still in use");

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_POINTS))
        else $error("point count beyond store depth");

    a_release_busy: assert property (@(posedge clk) disable iff (!rst_n)
        bank_rel.en |-> busy_reg[bank_rel.bank])
        else $error("release of a bank that holds no line");

endmodule

>>> rtl/pea_cordic.sv
// Iterative vectoring CORDIC atan2, one rotation step per cycle, Q3.13 result.
module pea_cordic import pea_pkg::*; #(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
    localparam int STEP_W = $clog2(CORDIC_STEPS)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [32:0] dy,
    input  logic signed [32:0] dx,
    output logic               busy,
    output logic               done,
    output logic signed [15:0] angle
);

    cordic_state_t st_reg, st_next;
    logic signed [CRD_XW-1:0] x_reg, x_next;
    logic signed [CRD_XW-1:0] y_reg, y_next;
    logic signed [CRD_ZW-1:0] z_reg, z_next;
    logic [STEP_W-1:0]        i_reg, i_next;
    logic                     done_reg, done_next;
    logic signed [15:0]       angle_reg, angle_next;

    logic signed [CRD_XW-1:0] xe, ye, xs, ys;
    logic signed [CRD_ZW-1:0] a;
    logic [CRD_ZW-1:0]        mag, rs;
    logic [15:0]              rc;

    always_comb
    begin
        st_next    = st_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        z_next     = z_reg;
        i_next     = i_reg;
        done_next  = 1'b0;
        angle_next = angle_reg;

        xe  = CRD_XW'(dx);
        ye  = CRD_XW'(dy);
        xs  = x_reg >>> i_reg;
        ys  = y_reg >>> i_reg;
        a   = atan_entry(5'(i_reg));
        mag = z_reg[CRD_ZW-1] ? CRD_ZW'(-z_reg) : CRD_ZW'(z_reg);
        rs  = (mag + CRD_ZW'(65536)) >> 17;
        rc  = (rs > CRD_ZW'(PI_Q13)) ? PI_Q13 : rs[15:0];

        unique case (st_reg)
            CR_IDLE:
            begin
                if (start)
                begin
                    if (dy == '0)
                    begin
                        angle_next = dx[32] ? $signed(PI_Q13) : 16'sd0;
                        done_next  = 1'b1;
                    end
                    else
                    begin
                        // fold the left half-plane onto the right one
                        x_next  = dx[32] ? -xe : xe;
                        y_next  = dx[32] ? -ye : ye;
                        z_next  = dx[32] ? (dy[32] ? -PI_Q30 : PI_Q30) : '0;
                        i_next  = '0;
                        st_next = CR_ROT;
                    end
                end
            end
            CR_ROT:
            begin
                if (y_reg > 0)
                begin
                    x_next = x_reg + ys;
                    y_next = y_reg - xs;
                    z_next = z_reg + a;
                end
                else
                begin
                    x_next = x_reg - ys;
                    y_next = y_reg + xs;
                    z_next = z_reg - a;
                end
                if (i_reg == STEP_W'(CORDIC_STEPS - 1))
                begin
                    st_next = CR_FIN;
                end
                else
                begin
                    i_next = i_reg + STEP_W'(1);
                end
            end
            CR_FIN:
            begin
                angle_next = z_reg[CRD_ZW-1] ? -$signed(rc) : $signed(rc);
                done_next  = 1'b1;
                st_next    = CR_IDLE;
            end
            default:
            begin
                st_next = CR_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= CR_IDLE;
            done_reg <= 1'b0;
        end
        else
        begin
            st_reg   <= st_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg     <= x_next;
        y_reg     <= y_next;
        z_reg     <= z_next;
        i_reg     <= i_next;
        angle_reg <= angle_next;
    end

    assign busy  = (st_reg != CR_IDLE);
    assign done  = done_reg;
    assign angle = angle_reg;

endmodule

>>> rtl/pea_back.sv
// Angle engine: takes closed lines and, for normal lines, scans the store backward and runs both atan2s.
module pea_back import pea_pkg::*; #(
    parameter int MAX_POINTS = MAX_POINTS_DEF,
    localparam int IDX_W = $clog2(MAX_POINTS)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [30:0]        threshold,
    input  logic               job_empty,
    input  job_t               job,
    output logic               pop,
    output logic               rd_en,
    output logic [IDX_W:0]     rd_addr,
    input  point_t             rd_data,
    output logic               cord_start,
    output logic signed [32:0] cord_dy,
    output logic signed [32:0] cord_dx,
    input  logic               cord_busy,
    input  logic               cord_done,
    input  logic signed [15:0] cord_angle,
    output logic               out_valid,
    input  logic               out_ready,
    output out_item_t          out_data,
    output bank_release_t      bank_rel
);

    back_state_t        state_reg, state_next;
    job_t               job_reg, job_next;
    point_t             tgt_reg, tgt_next;
    logic signed [15:0] beg_reg, beg_next;
    logic signed [15:0] end_reg, end_next;
    logic [IDX_W-1:0]   rd_idx_reg, rd_idx_next;
    logic               issue_done_reg, issue_done_next;
    logic               pend_reg, pend_next;
    logic               out_valid_reg, out_valid_next;
    out_item_t          out_data_reg, out_data_next;

    logic   issue_en;
    point_t from_pt;
    point_t to_pt;

    always_comb
    begin
        from_pt = (state_reg == BK_END_GO) ? job_reg.p_last : job_reg.p_first;
        to_pt   = (state_reg == BK_END_GO) ? tgt_reg : job_reg.p_begin;
        cord_dy = 33'(to_pt.y) - 33'(from_pt.y);
        cord_dx = 33'(to_pt.x) - 33'(from_pt.x);
    end

    always_comb
    begin
        state_next      = state_reg;
        job_next        = job_reg;
        tgt_next        = tgt_reg;
        beg_next        = beg_reg;
        end_next        = end_reg;
        rd_idx_next     = rd_idx_reg;
        issue_done_next = issue_done_reg;
        pend_next       = 1'b0;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        pop             = 1'b0;
        cord_start      = 1'b0;
        bank_rel.en     = 1'b0;
        bank_rel.bank   = job_reg.bank;
        issue_en        = (state_reg == BK_SCAN) && !issue_done_reg;
        rd_en           = issue_en;
        rd_addr         = {job_reg.bank, rd_idx_reg};

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            BK_IDLE:
            begin
                if (!job_empty)
                begin
                    pop      = 1'b1;
                    job_next = job;
                    beg_next = '0;
                    end_next = '0;
                    state_next = (job.status == ST_NORMAL) ? BK_BEG_GO : BK_OUT;
                end
            end
            BK_BEG_GO:
            begin
                cord_start = 1'b1;
                state_next = BK_BEG_WAIT;
            end
            BK_BEG_WAIT:
            begin
                if (cord_done)
                begin
                    beg_next = cord_angle;
                    if (job_reg.do_scan)
                    begin
                        rd_idx_next     = job_reg.scan_start[IDX_W-1:0];
                        issue_done_next = 1'b0;
                        state_next      = BK_SCAN;
                    end
                    else
                    begin
                        tgt_next   = job_reg.p_before_last;
                        state_next = BK_END_GO;
                    end
                end
            end
            BK_SCAN:
            begin
                // walk from the point before the last down to point 1
                pend_next = issue_en;
                if (issue_en)
                begin
                    rd_idx_next     = rd_idx_reg - IDX_W'(1);
                    issue_done_next = (rd_idx_reg == IDX_W'(1));
                end
                if (pend_reg)
                begin
                    if (differs(rd_data, job_reg.p_last, threshold))
                    begin
                        tgt_next   = rd_data;
                        state_next = BK_END_GO;
                    end
                    else if (issue_done_reg)
                    begin
                        tgt_next   = job_reg.p_before_last;
                        state_next = BK_END_GO;
                    end
                end
            end
            BK_END_GO:
            begin
                cord_start = 1'b1;
                state_next = BK_END_WAIT;
            end
            BK_END_WAIT:
            begin
                if (cord_done)
                begin
                    end_next   = cord_angle;
                    state_next = BK_OUT;
                end
            end
            BK_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next                 = 1'b1;
                    out_data_next.begin_angle      = beg_reg;
                    out_data_next.end_angle        = end_reg;
                    out_data_next.line_status      = job_reg.status;
                    out_data_next.within_threshold = job_reg.near_all;
                    bank_rel.en                    = 1'b1;
                    state_next                     = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= BK_IDLE;
            out_valid_reg  <= 1'b0;
            pend_reg       <= 1'b0;
            issue_done_reg <= 1'b1;
        end
        else
        begin
            state_reg      <= state_next;
            out_valid_reg  <= out_valid_next;
            pend_reg       <= pend_next;
            issue_done_reg <= issue_done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg      <= job_next;
        tgt_reg      <= tgt_next;
        beg_reg      <= beg_next;
        end_reg      <= end_next;
        rd_idx_reg   <= rd_idx_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cord_start |-> !cord_busy)
        else $error("atan2 started while the unit is busy");

    a_scan_read: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> state_reg == BK_SCAN || $past(state_reg) == BK_SCAN)
        else $error("store read outside the backward scan");

    a_release_out: assert property (@(posedge clk) disable iff (!rst_n)
        bank_rel.en |=> out_valid_reg)
        else $error("bank released without a result");

endmodule

>>> rtl/polyline_end_angles.sv
// Top level of the polyline end-angle block.
// Points stream in at one per cycle while in_ready is high and are written to a
// two-bank point store; the point marked last closes the line and the next line
// may start loading into the other bank at once. Per closed normal line the angle
// engine runs two CORDIC atan2s (a horizontal direction skips the rotation steps)
// and, for lines of more than two points, reads points backward from the store (at
// most n-2, stopping at the first point that differs from the last) through its
// single read port. Loading stalls only when both banks still hold lines waiting
// for the engine or for the output register to take their result. One result per
// line, on the last point.
module polyline_end_angles import pea_pkg::*; #(
    parameter int MAX_POINTS   = MAX_POINTS_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  in_item_t    in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output out_item_t   out_data,
    input  logic        cfg_wr_en,
    input  logic [30:0] cfg_wr_data
);

    localparam int IDX_W     = $clog2(MAX_POINTS);
    localparam int RAM_DEPTH = 2 ** (IDX_W + 1);

    logic [30:0] threshold_reg, threshold_next;

    logic          wr_en;
    logic [IDX_W:0] wr_addr;
    point_t        wr_data;
    logic          rd_en;
    logic [IDX_W:0] rd_addr;
    logic [63:0]   rd_raw;
    logic          push;
    job_t          push_job;
    logic          pop;
    job_t          head_job;
    logic          job_empty;
    bank_release_t bank_rel;
    logic               cord_start;
    logic signed [32:0] cord_dy;
    logic signed [32:0] cord_dx;
    logic               cord_busy;
    logic               cord_done;
    logic signed [15:0] cord_angle;

    assign threshold_next = cfg_wr_en ? cfg_wr_data : threshold_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= '0;
        end
        else
        begin
            threshold_reg <= threshold_next;
        end
    end

    pea_front #(.MAX_POINTS(MAX_POINTS)) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .threshold(threshold_reg),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .push     (push),
        .push_job (push_job),
        .bank_rel (bank_rel)
    );

    pea_ram #(.WIDTH(64), .DEPTH(RAM_DEPTH)) u_store (
        .clk    (clk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(64'(wr_data)),
        .rd_en  (rd_en),
        .rd_addr(rd_addr),
        .rd_data(rd_raw)
    );

    pea_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_job(push_job),
        .pop     (pop),
        .head_job(head_job),
        .empty   (job_empty)
    );

    pea_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
        .clk  (clk),
        .rst_n(rst_n),
        .start(cord_start),
        .dy   (cord_dy),
        .dx   (cord_dx),
        .busy (cord_busy),
        .done (cord_done),
        .angle(cord_angle)
    );

    pea_back #(.MAX_POINTS(MAX_POINTS)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .threshold (threshold_reg),
        .job_empty (job_empty),
        .job       (head_job),
        .pop       (pop),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (point_t'(rd_raw)),
        .cord_start(cord_start),
        .cord_dy   (cord_dy),
        .cord_dx   (cord_dx),
        .cord_busy (cord_busy),
        .cord_done (cord_done),
        .cord_angle(cord_angle),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .bank_rel  (bank_rel)
    );

endmodule
